### rtl/core/vaus_pkg.sv
// Shared types and constants for the MPEG-1 video access unit scanner.
// Used by every module under rtl/core; no dependencies.
`default_nettype none
package vaus_pkg;

  localparam int POS_BITS = 32;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    PH_START, PH_BODY, PH_SCAN, PH_PIC1, PH_PIC2, PH_HALT
  } phase_t;

  localparam logic [1:0] REC_UNIT   = 2'd0;
  localparam logic [1:0] REC_HEADER = 2'd1;
  localparam logic [1:0] REC_ERROR  = 2'd2;

  localparam logic [7:0] SC_SEQ_HDR = 8'hB3;
  localparam logic [7:0] SC_GROUP   = 8'hB8;
  localparam logic [7:0] SC_PICTURE = 8'h00;
  localparam logic [7:0] SC_SEQ_END = 8'hB7;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [23:0] unit_length;
    logic [2:0]  picture_type;
    logic [32:0] decode_time;
    logic [32:0] present_time;
    logic        ends_sequence;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  picture_rate_code;
    logic [17:0] bit_rate_code;
    logic [23:0] picture_count;
    logic [23:0] group_count;
  } rec_t;

  // frame period in quarter 90 kHz ticks, by picture rate code
  function automatic logic [13:0] qticks(input logic [3:0] code);
    logic [13:0] q;
    unique case (code)
      4'd1: q = 14'd15015;
      4'd2: q = 14'd15000;
      4'd4: q = 14'd12012;
      4'd5: q = 14'd12000;
      4'd6: q = 14'd7200;
      4'd7: q = 14'd6006;
      4'd8: q = 14'd6000;
      default: q = 14'd14400;
    endcase
    return q;
  endfunction

endpackage
`default_nettype wire

### rtl/core/vaus_front.sv
// Front part: parses the byte stream, tracks start codes and counters,
// and builds result records. Depends on vaus_pkg.
`default_nettype none
module vaus_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              take,
  input  wire [7:0]        stream_byte,
  output logic             push,
  output vaus_pkg::rec_t   rec
);
  import vaus_pkg::*;

  localparam logic [POS_BITS-1:0] LEN_MAX = POS_BITS'(24'hFFFFFF);

  phase_t              phase, phase_next;
  logic [POS_BITS-1:0] bpos, ustart, ustart_next;
  logic [23:0]         win, win_next;
  logic [63:0]         hs, hs_next;
  logic [13:0]         qt, qt_next;
  logic [31:0]         dord, dord_next, oig, oig_next;
  logic [2:0]          ctype, ctype_next;
  logic [32:0]         cdt, cpt;
  logic [23:0]         pics, pics_next, grps, grps_next;
  logic                mul_pend, mul_start;
  logic [31:0]         m_dord;
  logic signed [34:0]  m_cnt, cnt;
  logic [45:0]         prod_d;
  logic [47:0]         prod_p;
  logic                emit;
  logic [POS_BITS-1:0] end_pos, diff;
  logic                ends;

  assign diff = end_pos - ustart;
  assign prod_d = m_dord * qt;
  assign prod_p = m_cnt[33:0] * qt;

  always_comb begin
    phase_next = phase;
    ustart_next = ustart;
    win_next = win;
    hs_next = hs;
    qt_next = qt;
    dord_next = dord;
    oig_next = oig;
    ctype_next = ctype;
    pics_next = pics;
    grps_next = grps;
    mul_start = 1'b0;
    emit = 1'b0;
    ends = 1'b0;
    end_pos = bpos;
    cnt = '0;
    push = 1'b0;
    rec = '0;
    unique case (phase)
      PH_START: begin
        hs_next = {hs[55:0], stream_byte};
        if (bpos >= POS_BITS'(3)) begin
          if (hs_next[31:0] == 32'h000001B3) begin
            phase_next = PH_BODY;
            hs_next = '0;
          end else begin
            rec.record_kind = REC_ERROR;
            push = 1'b1;
            phase_next = PH_HALT;
          end
        end
      end
      PH_BODY: begin
        hs_next = {hs[55:0], stream_byte};
        if (bpos >= POS_BITS'(11)) begin
          push = 1'b1;
          if (!hs_next[13]) begin
            rec.record_kind = REC_ERROR;
            phase_next = PH_HALT;
          end else begin
            rec.record_kind = REC_HEADER;
            rec.frame_width = hs_next[63:52];
            rec.frame_height = hs_next[51:40];
            rec.picture_rate_code = hs_next[35:32];
            rec.bit_rate_code = hs_next[31:14];
            qt_next = qticks(hs_next[35:32]);
            win_next = 24'hFFFFFF;
            phase_next = PH_SCAN;
          end
        end
      end
      PH_SCAN: begin
        if (win == 24'h000001) begin
          win_next = 24'hFFFFFF;
          case (stream_byte)
            SC_GROUP: begin
              if (grps != 24'hFFFFFF) grps_next = grps + 24'd1;
              oig_next = '0;
            end
            SC_PICTURE: begin
              end_pos = bpos - POS_BITS'(3);
              emit = (ctype != 3'd0);
              phase_next = PH_PIC1;
            end
            SC_SEQ_END: begin
              end_pos = bpos + POS_BITS'(1);
              emit = 1'b1;
              ends = 1'b1;
            end
            default: ;
          endcase
        end else begin
          win_next = {win[15:0], stream_byte};
        end
      end
      PH_PIC1: begin
        hs_next = {56'd0, stream_byte};
        phase_next = PH_PIC2;
      end
      PH_PIC2: begin
        cnt = $signed({25'd0, hs[7:0], stream_byte[7:6]}) - $signed({3'd0, oig})
              + 35'sd1 + $signed({3'd0, dord});
        ctype_next = stream_byte[5:3];
        mul_start = 1'b1;
        dord_next = dord + 32'd1;
        oig_next = oig + 32'd1;
        if (pics != 24'hFFFFFF) pics_next = pics + 24'd1;
        win_next = 24'hFFFFFF;
        phase_next = PH_SCAN;
      end
      default: phase_next = PH_HALT;
    endcase
    if (emit) begin
      push = 1'b1;
      rec.record_kind = REC_UNIT;
      rec.unit_length = (diff > LEN_MAX) ? 24'hFFFFFF : diff[23:0];
      rec.picture_type = ctype;
      rec.decode_time = cdt;
      rec.present_time = cpt;
      rec.ends_sequence = ends;
      ustart_next = end_pos;
    end
    if (push) begin
      rec.picture_count = pics_next;
      rec.group_count = grps_next;
    end
    push = push & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      bpos <= '0;
      ustart <= '0;
      win <= 24'hFFFFFF;
      hs <= '0;
      qt <= 14'd14400;
      dord <= '0;
      oig <= '0;
      ctype <= '0;
      cdt <= '0;
      cpt <= '0;
      pics <= '0;
      grps <= '0;
      mul_pend <= 1'b0;
    end else begin
      mul_pend <= take && mul_start;
      if (mul_pend) begin
        cdt <= prod_d[34:2];
        cpt <= m_cnt[34] ? 33'd0 : prod_p[34:2];
      end
      if (take && phase != PH_HALT) begin
        phase <= phase_next;
        bpos <= bpos + POS_BITS'(1);
        ustart <= ustart_next;
        win <= win_next;
        hs <= hs_next;
        qt <= qt_next;
        dord <= dord_next;
        oig <= oig_next;
        ctype <= ctype_next;
        pics <= pics_next;
        grps <= grps_next;
      end
    end
  end

  // operands for the time products, registered when the picture type byte is taken
  always_ff @(posedge clk) begin
    if (take && mul_start) begin
      m_dord <= dord;
      m_cnt <= cnt;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT) else $error("left halt");
  a_push_on_take: assert property (@(posedge clk) disable iff (rst)
    push |-> take) else $error("push without byte");
  a_mul_once: assert property (@(posedge clk) disable iff (rst)
    mul_pend |-> phase == PH_SCAN) else $error("product not in scan");
`endif

endmodule
`default_nettype wire

### rtl/core/vaus_queue.sv
// Back part: short record queue whose head entry drives the result port.
// Depends on vaus_pkg.
`default_nettype none
module vaus_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  vaus_pkg::rec_t   din,
  output logic             full,
  output logic             rvalid,
  input  wire              rstall,
  output vaus_pkg::rec_t   dout
);
  import vaus_pkg::*;

  rec_t                  mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wptr, rptr;
  logic [Q_PTR_BITS:0]   count;
  logic                  pop;

  assign full = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign rvalid = (count != '0);
  assign pop = rvalid && !rstall;
  assign dout = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (Q_PTR_BITS+1)'(push) - (Q_PTR_BITS+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PTR_BITS+1)'(Q_DEPTH)) else $error("queue count out of range");
  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    rvalid && rstall |=> rvalid && $stable(rptr)) else $error("head moved");
`endif

endmodule
`default_nettype wire

### rtl/core/video_access_unit_scanner_core.sv
// MPEG-1 video access unit scanner, top level.
// Input channel: stream_valid / stream_stall carry one stream_byte per request.
// Output channel: record_valid / record_stall carry one record per request:
//   kind 0 access unit (length, type, 90 kHz times, sequence end flag),
//   kind 1 decoded sequence header, kind 2 header error.
// Throughput: one byte per cycle sustained; a byte is taken whenever the
// four-entry record queue has room.
// A record is written into the queue as the byte that causes it is taken, and is offered from the queue head.
// Reset (rst, synchronous) clears the parser to expect a sequence header and
// empties the queue. A header error halts the scanner until reset; bytes are
// still taken and dropped.
// When the receiver stalls, records pile up in the queue; once it holds four
// records stream_stall rises until one is taken.
// Requires vaus_pkg, vaus_front, vaus_queue.
`default_nettype none
module video_access_unit_scanner_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         stream_valid,
  output logic        stream_stall,
  input  wire [7:0]   stream_byte,
  output logic        record_valid,
  input  wire         record_stall,
  output logic [1:0]  record_kind,
  output logic [23:0] unit_length,
  output logic [2:0]  picture_type,
  output logic [32:0] decode_time,
  output logic [32:0] present_time,
  output logic        ends_sequence,
  output logic [11:0] frame_width,
  output logic [11:0] frame_height,
  output logic [3:0]  picture_rate_code,
  output logic [17:0] bit_rate_code,
  output logic [23:0] picture_count,
  output logic [23:0] group_count
);
  import vaus_pkg::*;

  logic take, push, full;
  rec_t rec, head;

  assign stream_stall = full;
  assign take = stream_valid && !full;

  vaus_front u_front (
    .clk(clk), .rst(rst), .take(take), .stream_byte(stream_byte),
    .push(push), .rec(rec)
  );

  vaus_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(rec), .full(full),
    .rvalid(record_valid), .rstall(record_stall), .dout(head)
  );

  assign record_kind = head.record_kind;
  assign unit_length = head.unit_length;
  assign picture_type = head.picture_type;
  assign decode_time = head.decode_time;
  assign present_time = head.present_time;
  assign ends_sequence = head.ends_sequence;
  assign frame_width = head.frame_width;
  assign frame_height = head.frame_height;
  assign picture_rate_code = head.picture_rate_code;
  assign bit_rate_code = head.bit_rate_code;
  assign picture_count = head.picture_count;
  assign group_count = head.group_count;

endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for video_access_unit_scanner_core: byte stream in, scanner records out.
// Holds its own scanner model and checks every record field by field.
// Depends on vaus_pkg and the scanner RTL.
`timescale 1ns / 1ps
module tb_top;
  import vaus_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        stream_valid = 1'b0;
  logic        stream_stall;
  logic [7:0]  stream_byte = 8'h00;
  logic        record_valid;
  logic        record_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [23:0] unit_length;
  logic [2:0]  picture_type;
  logic [32:0] decode_time;
  logic [32:0] present_time;
  logic        ends_sequence;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [3:0]  picture_rate_code;
  logic [17:0] bit_rate_code;
  logic [23:0] picture_count;
  logic [23:0] group_count;

  video_access_unit_scanner_core DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scanner model state
  logic [31:0] pos, unit_start, dec_order, grp_order;
  logic [23:0] window, pics, groups;
  logic [63:0] hdr_bits;
  logic [13:0] frame_qticks;
  logic [2:0]  cur_type;
  logic [32:0] cur_dts, cur_pts;
  logic [15:0] seqs;
  phase_t      phase;

  rec_t expected_records[$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   records_seen = 0;
  int   units_seen = 0;
  int   hold_cycles = 0;
  bit   quiet_mode = 1'b0;

  function automatic logic [13:0] rate_qticks(input logic [3:0] code);
    case (code)
      4'd1: return 14'd15015;
      4'd2: return 14'd15000;
      4'd4: return 14'd12012;
      4'd5: return 14'd12000;
      4'd6: return 14'd7200;
      4'd7: return 14'd6006;
      4'd8: return 14'd6000;
      default: return 14'd14400;
    endcase
  endfunction

  task automatic model_reset();
    pos = '0;
    unit_start = '0;
    dec_order = '0;
    grp_order = '0;
    window = 24'hFFFFFF;
    pics = '0;
    groups = '0;
    hdr_bits = '0;
    frame_qticks = 14'd14400;
    cur_type = '0;
    cur_dts = '0;
    cur_pts = '0;
    seqs = '0;
    phase = PH_START;
  endtask

  function automatic rec_t close_unit(input logic [31:0] end_pos, input logic ends);
    rec_t r;
    logic [31:0] len;
    r = '0;
    len = end_pos - unit_start;
    r.record_kind = REC_UNIT;
    r.unit_length = (len > 32'hFFFFFF) ? 24'hFFFFFF : len[23:0];
    r.picture_type = cur_type;
    r.decode_time = cur_dts;
    r.present_time = cur_pts;
    r.ends_sequence = ends;
    unit_start = end_pos;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    rec_t r;
    bit emit;
    logic [31:0] p;
    logic [9:0] tref;
    longint cnt;
    logic [63:0] prod;
    r = '0;
    emit = 1'b0;
    p = pos;
    if (phase == PH_HALT) return;
    pos = p + 32'd1;
    case (phase)
      PH_START: begin
        hdr_bits = {hdr_bits[55:0], b};
        if (p >= 32'd3) begin
          if (hdr_bits[31:0] == 32'h000001B3) begin
            phase = PH_BODY;
            hdr_bits = '0;
          end else begin
            r.record_kind = REC_ERROR;
            emit = 1'b1;
            phase = PH_HALT;
          end
        end
      end
      PH_BODY: begin
        hdr_bits = {hdr_bits[55:0], b};
        if (p >= 32'd11) begin
          emit = 1'b1;
          if (!hdr_bits[13]) begin
            r.record_kind = REC_ERROR;
            phase = PH_HALT;
          end else begin
            r.record_kind = REC_HEADER;
            r.frame_width = hdr_bits[63:52];
            r.frame_height = hdr_bits[51:40];
            r.picture_rate_code = hdr_bits[35:32];
            r.bit_rate_code = hdr_bits[31:14];
            frame_qticks = rate_qticks(hdr_bits[35:32]);
            if (seqs != 16'hFFFF) seqs++;
            window = 24'hFFFFFF;
            phase = PH_SCAN;
          end
        end
      end
      PH_SCAN: begin
        if (window == 24'h000001) begin
          window = 24'hFFFFFF;
          if (b == SC_SEQ_HDR) begin
            if (seqs != 16'hFFFF) seqs++;
          end else if (b == SC_GROUP) begin
            if (groups != 24'hFFFFFF) groups++;
            grp_order = '0;
          end else if (b == SC_PICTURE) begin
            if (cur_type != 3'd0) begin
              r = close_unit(p - 32'd3, 1'b0);
              emit = 1'b1;
            end
            phase = PH_PIC1;
          end else if (b == SC_SEQ_END) begin
            r = close_unit(p + 32'd1, 1'b1);
            emit = 1'b1;
          end
        end else begin
          window = {window[15:0], b};
        end
      end
      PH_PIC1: begin
        hdr_bits = {56'd0, b};
        phase = PH_PIC2;
      end
      PH_PIC2: begin
        tref = {hdr_bits[7:0], b[7:6]};
        cnt = longint'(tref) - longint'(grp_order) + 1 + longint'(dec_order);
        cur_type = b[5:3];
        prod = {32'd0, dec_order} * {50'd0, frame_qticks};
        cur_dts = prod[34:2];
        prod = cnt[63:0] * {50'd0, frame_qticks};
        cur_pts = (cnt < 0) ? 33'd0 : prod[34:2];
        dec_order++;
        grp_order++;
        if (pics != 24'hFFFFFF) pics++;
        window = 24'hFFFFFF;
        phase = PH_SCAN;
      end
      default: phase = PH_HALT;
    endcase
    if (emit) begin
      r.picture_count = pics;
      r.group_count = groups;
      expected_records.push_back(r);
    end
  endtask

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %0t: %s got %0h expected %0h", $realtime, field, got, want);
  endtask

  // one request on the byte channel, with a random gap in front unless in quiet mode
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet_mode)
      gap = ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 2))
                                        : int'($urandom_range(5, 30));
    if (gap > 0) begin
      stream_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (stream_stall);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_code(input logic [7:0] code);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(code);
  endtask

  task automatic send_picture(input logic [9:0] tref, input logic [2:0] ptype);
    send_code(SC_PICTURE);
    send_byte(tref[9:2]);
    send_byte({tref[1:0], ptype, 3'($urandom_range(0, 7))});
  endtask

  always @(posedge clk) begin
    rec_t e;
    if (!rst && record_valid && !record_stall) begin
      records_seen++;
      if (expected_records.size() == 0) begin
        report("unexpected record", 64'(record_kind), 64'd0);
      end else begin
        e = expected_records.pop_front();
        if (e.record_kind == REC_UNIT) units_seen++;
        if (record_kind !== e.record_kind)
          report("record_kind", 64'(record_kind), 64'(e.record_kind));
        if (unit_length !== e.unit_length)
          report("unit_length", 64'(unit_length), 64'(e.unit_length));
        if (picture_type !== e.picture_type)
          report("picture_type", 64'(picture_type), 64'(e.picture_type));
        if (decode_time !== e.decode_time)
          report("decode_time", 64'(decode_time), 64'(e.decode_time));
        if (present_time !== e.present_time)
          report("present_time", 64'(present_time), 64'(e.present_time));
        if (ends_sequence !== e.ends_sequence)
          report("ends_sequence", 64'(ends_sequence), 64'(e.ends_sequence));
        if (frame_width !== e.frame_width)
          report("frame_width", 64'(frame_width), 64'(e.frame_width));
        if (frame_height !== e.frame_height)
          report("frame_height", 64'(frame_height), 64'(e.frame_height));
        if (picture_rate_code !== e.picture_rate_code)
          report("picture_rate_code", 64'(picture_rate_code), 64'(e.picture_rate_code));
        if (bit_rate_code !== e.bit_rate_code)
          report("bit_rate_code", 64'(bit_rate_code), 64'(e.bit_rate_code));
        if (picture_count !== e.picture_count)
          report("picture_count", 64'(picture_count), 64'(e.picture_count));
        if (group_count !== e.group_count)
          report("group_count", 64'(group_count), 64'(e.group_count));
      end
    end
  end

  // receiver: long hold when asked, else random stalls with calm stretches
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      record_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet_mode) begin
      record_stall <= 1'b0;
    end else begin
      record_stall <= ($urandom_range(0, 19) < 4) ||
                      ($urandom_range(0, 199) == 0 && $urandom_range(0, 1) == 1);
    end
  end

  task automatic test_header();
    logic [63:0] h;
    h = {$urandom, $urandom};
    h[13] = 1'b1;
    send_code(SC_SEQ_HDR);
    for (int i = 7; i >= 0; i--) send_byte(h[i*8 +: 8]);
  endtask

  task automatic test_directed_codes();
    send_code(SC_GROUP);
    send_picture(10'd0, 3'd0);    // type zero unit: no record when the next picture starts
    send_picture(10'd1023, 3'd1);
    send_byte(8'hFF);
    send_picture(10'd2, 3'd2);
    send_picture(10'd1, 3'd3);
    send_picture(10'd0, 3'd4);
    send_code(8'hBA);             // ignored code
    send_code(SC_SEQ_HDR);
    send_code(SC_PICTURE);        // picture header bytes look like a start code prefix
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hB7);
    send_picture(10'd3, 3'd7);
    send_code(SC_SEQ_END);
    send_code(SC_SEQ_END);        // second end code still emits a unit, with the last picture type
  endtask

  task automatic test_random_stream(input int n_bytes);
    int stop;
    int k;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      quiet_mode = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 9);
      repeat ($urandom_range(0, 6))
        send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      if (k < 5) begin
        send_picture(10'($urandom), 3'($urandom_range(0, 7)));
      end else if (k == 5) begin
        send_code(SC_GROUP);
      end else if (k == 6) begin
        send_code(($urandom_range(0, 1) == 1) ? SC_SEQ_END : SC_SEQ_HDR);
      end else if (k == 7) begin
        send_code(8'($urandom));
      end else begin
        send_byte(8'h00);         // broken prefix
        send_byte(8'h00);
        send_byte(8'($urandom));
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_queue_full();
    hold_cycles <= 300;
    for (int i = 0; i < 12; i++) send_code(SC_SEQ_END);
    test_random_stream(40);
  endtask

  task automatic test_drain_pause();
    stream_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    test_random_stream(30);
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_header();
    test_directed_codes();
    test_random_stream(700);
    test_queue_full();
    test_drain_pause();
    test_random_stream(1000);
    stream_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("scanned %0d bytes, checked %0d records (%0d access units)",
             bytes_sent, records_seen, units_seen);
    if (errors == 0 && expected_records.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d records outstanding", expected_records.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

### sim.f
rtl/core/vaus_pkg.sv
rtl/core/vaus_front.sv
rtl/core/vaus_queue.sv
rtl/core/video_access_unit_scanner_core.sv
sim/tb_top.sv
